// ===== rtl/core/nearest_neighbor_tour_core_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the nearest neighbor tour core
// Two short forms of a clocked, reset-qualified concurrent assertion.
// ---------------------------------------------------------------------------
`ifndef NEAREST_NEIGHBOR_TOUR_CORE_MACROS_SVH
`define NEAREST_NEIGHBOR_TOUR_CORE_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define NNT_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define NNT_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/core/nnt_pkg.sv =====
// ---------------------------------------------------------------------------
// Nearest neighbor tour package
// Word types, cell control type and default sizes shared by the core.
// ---------------------------------------------------------------------------
package nnt_pkg;

   localparam int CITY_ID_BITS    = 16;
   localparam int IN_COORD_BITS   = 16;
   localparam int MAX_CITIES_DEF  = 64;
   localparam int COORD_BITS_DEF  = 16;

   // One city as it arrives on the request port.
   typedef struct packed {
      logic        [CITY_ID_BITS-1:0]  city_id;
      logic signed [IN_COORD_BITS-1:0] x_coord;
      logic signed [IN_COORD_BITS-1:0] y_coord;
      logic                            last_city;
   } req_type;

   // One tour entry as it leaves on the response port.
   typedef struct packed {
      logic [CITY_ID_BITS-1:0] tour_city;
      logic                    tour_end;
   } rsp_type;

   // Write controls broadcast to every cell.
   typedef struct packed {
      logic load;   // a new city is stored
      logic swap;   // the chosen city trades places with the one at the current position
   } cell_ctl_type;

endpackage

// ===== rtl/core/nnt_cell.sv =====
// ---------------------------------------------------------------------------
// Nearest neighbor tour cell
// Holds one city of the working order, keeps its squared distance to the
// current reference city and forwards the running best candidate.
// ---------------------------------------------------------------------------
module nnt_cell #(
   parameter int MAX_CITIES = nnt_pkg::MAX_CITIES_DEF,
   parameter int COORD_BITS = nnt_pkg::COORD_BITS_DEF,
   parameter int CELL_IDX   = 0,
   localparam int IW  = (MAX_CITIES > 1) ? $clog2(MAX_CITIES) : 1,
   localparam int CNW = $clog2(MAX_CITIES + 1),
   localparam int CW  = nnt_pkg::CITY_ID_BITS + 2 * COORD_BITS,
   localparam int SQW = 2 * COORD_BITS,
   localparam int DW  = SQW + 1
) (
   input  logic                    clock,
   input  logic                    reset,
   input  nnt_pkg::cell_ctl_type   ctl,
   input  logic [CW-1:0]           new_city,
   input  logic [CW-1:0]           head_city,
   input  logic [IW-1:0]           load_idx,
   input  logic [IW-1:0]           pos_idx,
   input  logic [CNW-1:0]          city_cnt,
   input  logic [IW-1:0]           swap_idx,
   input  logic [CW-1:0]           swap_best,
   input  logic [CW-1:0]           swap_disp,
   input  logic signed [COORD_BITS-1:0] ref_x,
   input  logic signed [COORD_BITS-1:0] ref_y,
   input  logic                    up_live,
   input  logic                    up_found,
   input  logic [DW-1:0]           up_dist,
   input  logic [IW-1:0]           up_idx,
   input  logic [CW-1:0]           up_best,
   input  logic [CW-1:0]           up_disp,
   output logic                    down_live,
   output logic                    down_found,
   output logic [DW-1:0]           down_dist,
   output logic [IW-1:0]           down_idx,
   output logic [CW-1:0]           down_best,
   output logic [CW-1:0]           down_disp,
   output logic [CW-1:0]           city
);
   import nnt_pkg::*;

   localparam logic [IW-1:0]  K_IDX = IW'(CELL_IDX);
   localparam logic [CNW-1:0] K_CNT = CNW'(CELL_IDX);

   logic [CW-1:0]  city_ff, city_in;
   logic [SQW-1:0] dx2_ff, dx2_in, dy2_ff, dy2_in;
   logic           live_ff, found_ff, found_in;
   logic [DW-1:0]  dist_ff, dist_in;
   logic [IW-1:0]  idx_ff, idx_in;
   logic [CW-1:0]  best_ff, best_in, disp_ff, disp_in;

   logic signed [COORD_BITS-1:0] own_x, own_y;
   logic signed [COORD_BITS:0]   dx, dy;
   logic [COORD_BITS:0]          dx_abs, dy_abs;
   logic [COORD_BITS-1:0]        dx_mag, dy_mag;
   logic [DW-1:0]                own_dist;
   logic                         active, take;

   assign own_x = city_ff[2*COORD_BITS-1 -: COORD_BITS];
   assign own_y = city_ff[COORD_BITS-1:0];

   // Squared distance to the reference, one register stage after the squares.
   always_comb begin
      dx     = {own_x[COORD_BITS-1], own_x} - {ref_x[COORD_BITS-1], ref_x};
      dy     = {own_y[COORD_BITS-1], own_y} - {ref_y[COORD_BITS-1], ref_y};
      dx_abs = dx[COORD_BITS] ? (~dx + 1'b1) : dx;
      dy_abs = dy[COORD_BITS] ? (~dy + 1'b1) : dy;
      dx_mag = dx_abs[COORD_BITS-1:0];
      dy_mag = dy_abs[COORD_BITS-1:0];
      dx2_in = SQW'(dx_mag) * SQW'(dx_mag);
      dy2_in = SQW'(dy_mag) * SQW'(dy_mag);
      own_dist = DW'(dx2_ff) + DW'(dy2_ff);
   end

   // A cell competes only if it still lies in the unvisited part of the order.
   // Strict less-than keeps the lower position on a tie.
   always_comb begin
      active   = (K_IDX >= pos_idx) && (K_CNT < city_cnt);
      take     = up_live && active && (!up_found || (own_dist < up_dist));
      found_in = up_found || take;
      dist_in  = take ? own_dist : up_dist;
      idx_in   = take ? K_IDX : up_idx;
      best_in  = take ? city_ff : up_best;
      disp_in  = (K_IDX == pos_idx) ? city_ff : up_disp;
   end

   // Loads put the newest city in cell 0 and move the previous newest to the
   // end of the filled range; a swap exchanges two cells of the order.
   always_comb begin
      city_in = city_ff;
      if (ctl.load) begin
         if (CELL_IDX == 0) begin
            city_in = new_city;
         end else if (K_IDX == load_idx) begin
            city_in = head_city;
         end
      end else if (ctl.swap) begin
         if (K_IDX == pos_idx) begin
            city_in = swap_best;
         end else if (K_IDX == swap_idx) begin
            city_in = swap_disp;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         live_ff <= 1'b0;
      end else begin
         live_ff <= up_live;
      end
   end

   always_ff @(posedge clock) begin
      city_ff  <= city_in;
      dx2_ff   <= dx2_in;
      dy2_ff   <= dy2_in;
      found_ff <= found_in;
      dist_ff  <= dist_in;
      idx_ff   <= idx_in;
      best_ff  <= best_in;
      disp_ff  <= disp_in;
   end

   assign down_live  = live_ff;
   assign down_found = found_ff;
   assign down_dist  = dist_ff;
   assign down_idx   = idx_ff;
   assign down_best  = best_ff;
   assign down_disp  = disp_ff;
   assign city       = city_ff;

endmodule

// ===== rtl/core/nearest_neighbor_tour_core.sv =====
// ---------------------------------------------------------------------------
// Nearest neighbor tour core
// Stores up to MAX_CITIES cities and builds a greedy nearest neighbor tour
// over them, giving out the city identifiers in tour order.
// ---------------------------------------------------------------------------
//
//   Channel   Ports                      Direction  Handshake
//   request   start, busy, req_data      in         word taken when start & !busy
//   response  rsp_strobe, rsp_data       out        word valid for the one strobe cycle
//
// A city that is not flagged last is stored and the core is ready again
// in the next cycle. The last city starts the tour; busy stays high
// until the final tour word has been sent. The first word is sent from
// the start state, and each further word waits for the trip of the
// best-candidate word down the full row of cells.
// Reset is synchronous and empties the store. The receiver cannot stall;
// every tour word is sent exactly once, in the cycle its strobe is high.
// ---------------------------------------------------------------------------
module nearest_neighbor_tour_core #(
   parameter int MAX_CITIES = nnt_pkg::MAX_CITIES_DEF,
   parameter int COORD_BITS = nnt_pkg::COORD_BITS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  nnt_pkg::req_type req_data,
   output logic             rsp_strobe,
   output nnt_pkg::rsp_type rsp_data
);
   import nnt_pkg::*;

   localparam int IW  = (MAX_CITIES > 1) ? $clog2(MAX_CITIES) : 1;
   localparam int CNW = $clog2(MAX_CITIES + 1);
   localparam int CW  = CITY_ID_BITS + 2 * COORD_BITS;
   localparam int DW  = 2 * COORD_BITS + 1;
   localparam int IN_BITS = (COORD_BITS < IN_COORD_BITS) ? COORD_BITS : IN_COORD_BITS;

   // Sequencer states.
   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_START  = 3'd1;
   localparam logic [2:0] ST_WAIT   = 3'd2;
   localparam logic [2:0] ST_LAUNCH = 3'd3;
   localparam logic [2:0] ST_RUN    = 3'd4;

   logic [2:0]                   state_ff, state_in;
   logic [CNW-1:0]               count_ff, count_in;
   logic [IW-1:0]                pos_ff, pos_in;
   logic signed [COORD_BITS-1:0] ref_x_ff, ref_x_in, ref_y_ff, ref_y_in;
   logic                         rsp_strobe_ff, rsp_strobe_in;
   rsp_type                      rsp_data_ff, rsp_data_in;

   cell_ctl_type                 ctl;
   logic                         accept, load_ok, launch, last_pos;
   logic signed [COORD_BITS-1:0] new_x, new_y;
   logic [CW-1:0]                new_city;

   // Best-candidate word as it travels down the row; entry 0 feeds cell 0.
   logic          tok_live  [MAX_CITIES+1];
   logic          tok_found [MAX_CITIES+1];
   logic [DW-1:0] tok_dist  [MAX_CITIES+1];
   logic [IW-1:0] tok_idx   [MAX_CITIES+1];
   logic [CW-1:0] tok_best  [MAX_CITIES+1];
   logic [CW-1:0] tok_disp  [MAX_CITIES+1];
   logic [CW-1:0] city_q    [MAX_CITIES];

   logic [CW-1:0] head_city, tail_best;

   // Coordinates are held COORD_BITS wide; a narrower width keeps only the
   // low bits of the incoming value, sign-extended from there.
   assign new_x    = COORD_BITS'($signed(req_data.x_coord[IN_BITS-1:0]));
   assign new_y    = COORD_BITS'($signed(req_data.y_coord[IN_BITS-1:0]));
   assign new_city = {req_data.city_id, new_x, new_y};

   assign busy    = (state_ff != ST_IDLE);
   assign accept  = start && !busy;
   // A city that arrives with the store full is dropped.
   assign load_ok = (count_ff < CNW'(MAX_CITIES));

   assign head_city = city_q[0];
   assign tail_best = tok_best[MAX_CITIES];

   // A fresh search word enters cell 0 with no candidate yet.
   assign tok_live[0]  = launch;
   assign tok_found[0] = 1'b0;
   assign tok_dist[0]  = '0;
   assign tok_idx[0]   = '0;
   assign tok_best[0]  = '0;
   assign tok_disp[0]  = '0;

   for (genvar k = 0; k < MAX_CITIES; k++) begin : g_cell
      nnt_cell #(
         .MAX_CITIES (MAX_CITIES),
         .COORD_BITS (COORD_BITS),
         .CELL_IDX   (k)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctl        (ctl),
         .new_city   (new_city),
         .head_city  (head_city),
         .load_idx   (count_ff[IW-1:0]),
         .pos_idx    (pos_ff),
         .city_cnt   (count_ff),
         .swap_idx   (tok_idx[MAX_CITIES]),
         .swap_best  (tail_best),
         .swap_disp  (tok_disp[MAX_CITIES]),
         .ref_x      (ref_x_ff),
         .ref_y      (ref_y_ff),
         .up_live    (tok_live[k]),
         .up_found   (tok_found[k]),
         .up_dist    (tok_dist[k]),
         .up_idx     (tok_idx[k]),
         .up_best    (tok_best[k]),
         .up_disp    (tok_disp[k]),
         .down_live  (tok_live[k+1]),
         .down_found (tok_found[k+1]),
         .down_dist  (tok_dist[k+1]),
         .down_idx   (tok_idx[k+1]),
         .down_best  (tok_best[k+1]),
         .down_disp  (tok_disp[k+1]),
         .city       (city_q[k])
      );
   end

   // The position being filled is the final one when it is one below the count.
   assign last_pos = ((CNW'(pos_ff) + CNW'(1)) == count_ff);

   // Sequencer. Cell 0 always holds the tour start, so its word goes out first
   // and becomes the reference. Each later position passes through a wait state
   // for the cells to square their distances, launches a search word, and on its
   // return swaps the winner into place, sends it and makes it the reference.
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      pos_in        = pos_ff;
      ref_x_in      = ref_x_ff;
      ref_y_in      = ref_y_ff;
      rsp_strobe_in = 1'b0;
      rsp_data_in   = rsp_data_ff;
      ctl           = '0;
      launch        = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               ctl.load = load_ok;
               if (load_ok) begin
                  count_in = count_ff + CNW'(1);
               end
               if (req_data.last_city) begin
                  state_in = ST_START;
               end
            end
         end
         ST_START: begin
            rsp_strobe_in         = 1'b1;
            rsp_data_in.tour_city = head_city[CW-1 -: CITY_ID_BITS];
            rsp_data_in.tour_end  = (count_ff == CNW'(1));
            ref_x_in              = head_city[2*COORD_BITS-1 -: COORD_BITS];
            ref_y_in              = head_city[COORD_BITS-1:0];
            if (count_ff == CNW'(1)) begin
               state_in = ST_IDLE;
               count_in = '0;
            end else begin
               pos_in   = IW'(1);
               state_in = ST_WAIT;
            end
         end
         ST_WAIT: begin
            state_in = ST_LAUNCH;
         end
         ST_LAUNCH: begin
            launch   = 1'b1;
            state_in = ST_RUN;
         end
         ST_RUN: begin
            if (tok_live[MAX_CITIES]) begin
               ctl.swap              = 1'b1;
               rsp_strobe_in         = 1'b1;
               rsp_data_in.tour_city = tail_best[CW-1 -: CITY_ID_BITS];
               rsp_data_in.tour_end  = last_pos;
               ref_x_in              = tail_best[2*COORD_BITS-1 -: COORD_BITS];
               ref_y_in              = tail_best[COORD_BITS-1:0];
               if (last_pos) begin
                  state_in = ST_IDLE;
                  count_in = '0;
               end else begin
                  pos_in   = pos_ff + IW'(1);
                  state_in = ST_WAIT;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff      <= pos_in;
      ref_x_ff    <= ref_x_in;
      ref_y_ff    <= ref_y_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

endmodule

// ===== rtl/core/nnt_checker.sv =====
// ---------------------------------------------------------------------------
// Nearest neighbor tour checker
// Port-level checks on how tour words and the busy flag line up in time.
// ---------------------------------------------------------------------------
`include "nearest_neighbor_tour_core_macros.svh"

module nnt_checker (
   input logic             clock,
   input logic             reset,
   input logic             start,
   input logic             busy,
   input nnt_pkg::req_type req_data,
   input logic             rsp_strobe,
   input nnt_pkg::rsp_type rsp_data
);
   import nnt_pkg::*;

   // Tour words only come out of a tour that was running in the previous cycle.
   `NNT_ASSERT_SAME(a_word_from_tour, rsp_strobe, $past(busy), "tour word without a running tour")

   // The flagged final word closes the tour; any other word leaves it running.
   `NNT_ASSERT_SAME(a_end_matches_busy, rsp_strobe, busy == !rsp_data.tour_end, "tour end flag and busy disagree")

   // A last city always starts a tour.
   `NNT_ASSERT_NEXT(a_last_starts, start && !busy && req_data.last_city, busy, "last city did not start a tour")

   // Storing an ordinary city is silent and leaves the core ready in the next cycle.
   `NNT_ASSERT_NEXT(a_load_silent, start && !busy && !req_data.last_city, !busy && !rsp_strobe, "ordinary city caused activity")

   // Tour words are always spaced apart.
   `NNT_ASSERT_NEXT(a_word_spacing, rsp_strobe, !rsp_strobe, "tour words back to back")

endmodule

bind nearest_neighbor_tour_core nnt_checker u_nnt_checker (.*);

// ===== tb/nearest_neighbor_tour_core_tb.sv =====
// ---------------------------------------------------------------------------
// Nearest neighbor tour core testbench
// Loads batches of cities into the core and checks every tour word against
// a behavioral copy of the greedy nearest neighbor search. The run covers
// single-city tours, equal-distance ties, coordinate extremes and a full
// store with dropped cities. It then closes with random batches sent
// without idle gaps.
// ---------------------------------------------------------------------------
module nearest_neighbor_tour_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import nnt_pkg::*;

   localparam int MAX_CITIES   = MAX_CITIES_DEF;
   localparam int COORD_BITS   = COORD_BITS_DEF;
   // The wait after the queue has drained leaves ample time for a stray tour
   // word to show up.
   localparam int SETTLE_WAIT  = 2 * (MAX_CITIES + 2) + 20;
   // The limit leaves wide margin over the slowest correct run.
   localparam int CYCLE_LIMIT  = 400000;

   // How the coordinates of a random batch are spread.
   typedef enum int {
      SPREAD_FULL,    // anywhere in the signed 16-bit range
      SPREAD_TIGHT,   // a 7x7 grid around the origin, where distance ties are common
      SPREAD_MIXED    // per coordinate: full range, tight grid or a range extreme
   } coord_spread_type;

   // One city waiting to be offered to the core.
   typedef struct {
      req_type word;
      int      gap;     // idle cycles before the word is offered
      bit      drain;   // hold the word until every tour word due has arrived
   } pending_city_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   req_type req_data = '0;
   logic    rsp_strobe;
   rsp_type rsp_data;

   pending_city_type city_queue [$];
   rsp_type          tour_due [$];

   // Mirror of the core's city store.
   logic [CITY_ID_BITS-1:0]         city_ids [MAX_CITIES];
   logic signed [IN_COORD_BITS-1:0] city_x   [MAX_CITIES];
   logic signed [IN_COORD_BITS-1:0] city_y   [MAX_CITIES];
   int                              stored_count = 0;

   int cities_sent   = 0;
   int tours_built   = 0;
   int largest_tour  = 0;
   int words_checked = 0;
   int mismatches    = 0;
   int idle_run      = 0;
   int cycle_count   = 0;

   nearest_neighbor_tour_core #(
      .MAX_CITIES (MAX_CITIES),
      .COORD_BITS (COORD_BITS)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // -------------------------------------------------------------------------
   // Tour prediction
   // -------------------------------------------------------------------------

   // Squared Euclidean distance between two stored cities. A coordinate
   // difference needs 17 bits, so the sum of squares fits easily in 64 bits.
   function automatic longint sq_dist(int a, int b);
      longint dx, dy;
      dx = longint'(city_x[a]) - longint'(city_x[b]);
      dy = longint'(city_y[a]) - longint'(city_y[b]);
      return dx * dx + dy * dy;
   endfunction

   // The greedy search. The walk starts at the most recently stored city,
   // followed by the others in load order. Each position takes the closest
   // remaining city. On equal distances the strict compare keeps the lowest
   // working position.
   function automatic void build_tour();
      int      order [MAX_CITIES];
      int      n, best, held;
      longint  best_d, d;
      rsp_type word;
      n = stored_count;
      order[0] = n - 1;
      for (int i = 1; i < n; i++) order[i] = i - 1;
      for (int i = 1; i < n; i++) begin
         best   = i;
         best_d = sq_dist(order[i], order[i-1]);
         for (int j = i + 1; j < n; j++) begin
            d = sq_dist(order[j], order[i-1]);
            if (d < best_d) begin
               best_d = d;
               best   = j;
            end
         end
         held        = order[i];
         order[i]    = order[best];
         order[best] = held;
      end
      for (int i = 0; i < n; i++) begin
         word.tour_city = city_ids[order[i]];
         word.tour_end  = (i == n - 1);
         tour_due = {tour_due, word};
      end
      tours_built++;
      if (n > largest_tour) largest_tour = n;
      stored_count = 0;
   endfunction

   // Called for every accepted word. A city that arrives at a full store is
   // dropped, but its last flag still starts the tour over what is stored.
   function automatic void store_city(req_type word);
      if (stored_count < MAX_CITIES) begin
         city_ids[stored_count] = word.city_id;
         city_x[stored_count]   = word.x_coord;
         city_y[stored_count]   = word.y_coord;
         stored_count++;
      end
      cities_sent++;
      if (word.last_city) build_tour();
   endfunction

   // -------------------------------------------------------------------------
   // Stimulus construction
   // -------------------------------------------------------------------------

   task automatic queue_city(input logic [15:0] id, input logic [15:0] x,
                             input logic [15:0] y, input bit last,
                             input int gap, input bit drain);
      pending_city_type item;
      item.word.city_id   = id;
      item.word.x_coord   = x;
      item.word.y_coord   = y;
      item.word.last_city = last;
      item.gap            = gap;
      item.drain          = drain;
      city_queue = {city_queue, item};
   endtask

   function automatic logic [15:0] pick_coord(coord_spread_type spread);
      int choice;
      choice = (spread == SPREAD_MIXED) ? $urandom_range(0, 2) : int'(spread);
      case (choice)
         SPREAD_FULL:  return 16'($urandom);
         SPREAD_TIGHT: return 16'($urandom_range(0, 6) - 3);
         default: begin
            case ($urandom_range(0, 3))
               0:       return 16'h8000;
               1:       return 16'h7FFF;
               2:       return 16'h0000;
               default: return 16'hFFFF;
            endcase
         end
      endcase
   endfunction

   // A batch always ends with the last flag set, so every stored city is
   // checked through a tour. Some words get an idle gap of random length.
   // Some batches get no gaps at all.
   task automatic queue_batch(input int size, input bit idle_ok, input bit drain);
      coord_spread_type spread;
      bit               gappy;
      int               gap;
      spread = coord_spread_type'($urandom_range(0, 2));
      gappy  = idle_ok && ($urandom_range(0, 2) != 0);
      for (int i = 0; i < size; i++) begin
         gap = (gappy && $urandom_range(0, 2) == 0) ? $urandom_range(1, 12) : 0;
         queue_city(16'($urandom), pick_coord(spread), pick_coord(spread),
                    i == size - 1, gap, drain && i == 0);
      end
   endtask

   initial begin
      int random_words;

      // Directed part. Single-city tours at the field extremes.
      queue_city(16'hFFFF, 16'h7FFF, 16'h8000, 1'b1, 0, 1'b0);
      queue_city(16'h0000, 16'h8000, 16'h7FFF, 1'b1, 3, 1'b0);
      // The four corners of the coordinate range, for the largest distances.
      queue_city(16'h0001, 16'h8000, 16'h8000, 1'b0, 0, 1'b0);
      queue_city(16'h0002, 16'h7FFF, 16'h7FFF, 1'b0, 0, 1'b0);
      queue_city(16'h0003, 16'h8000, 16'h7FFF, 1'b0, 1, 1'b0);
      queue_city(16'h0004, 16'h7FFF, 16'h8000, 1'b1, 0, 1'b0);
      // A ring of four cities around a start at the origin. Every first step
      // is a tie, and the later steps tie again across the ring.
      queue_city(16'h0101, 16'h0001, 16'h0000, 1'b0, 0, 1'b1);
      queue_city(16'h0102, 16'h0000, 16'h0001, 1'b0, 0, 1'b0);
      queue_city(16'h0103, 16'hFFFF, 16'h0000, 1'b0, 12, 1'b0);
      queue_city(16'h0104, 16'h0000, 16'hFFFF, 1'b0, 0, 1'b0);
      queue_city(16'h0100, 16'h0000, 16'h0000, 1'b1, 0, 1'b0);
      // Cities on one point, so every distance is zero.
      queue_city(16'h000A, 16'h0005, 16'h0005, 1'b0, 0, 1'b0);
      queue_city(16'h000B, 16'h0005, 16'h0005, 1'b0, 0, 1'b0);
      queue_city(16'h000C, 16'h0005, 16'h0005, 1'b1, 0, 1'b0);
      // Alternating bit patterns on every field.
      queue_city(16'hAAAA, 16'h5555, 16'hAAAA, 1'b0, 0, 1'b0);
      queue_city(16'h5555, 16'hAAAA, 16'h5555, 1'b1, 0, 1'b0);

      // Random part. The first batch waits for the directed tours to finish.
      random_words = 0;
      while (random_words < 8) begin
         int size;
         size = $urandom_range(1, 6);
         queue_batch(size, 1'b1, random_words == 0 || $urandom_range(0, 3) == 0);
         random_words += size;
      end
      // A full store. The 65th city is dropped, and so is the 66th, which
      // still triggers a tour over the 64 stored cities.
      queue_batch(MAX_CITIES + 2, 1'b1, 1'b0);
      // The tail runs with no idle gaps.
      random_words = 0;
      while (random_words < 12) begin
         int size;
         size = $urandom_range(1, 8);
         queue_batch(size, 1'b0, 1'b0);
         random_words += size;
      end

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      while (city_queue.size() != 0 || start || tour_due.size() != 0) @(posedge clock);
      repeat (SETTLE_WAIT) @(posedge clock);

      $display("Sent %0d city words in %0d tours, the largest of %0d cities.",
               cities_sent, tours_built, largest_tour);
      $display("Checked %0d tour words, with ties, extremes and a full store.",
               words_checked);
      if (mismatches == 0) begin
         $display("nearest_neighbor_tour_core test passed");
      end else begin
         $display("nearest_neighbor_tour_core test failed");
      end
      $finish;
   end

   // -------------------------------------------------------------------------
   // Driver: a word is taken on a rising edge where start is high and busy is
   // low. The edge that takes a word also decides what the next cycle offers,
   // and start is assigned once per edge.
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      logic taken;
      if (reset) begin
         start    <= 1'b0;
         idle_run  = 0;
      end else begin
         taken = start && !busy;
         if (taken) store_city(req_data);
         if (taken || !start) begin
            if (city_queue.size() == 0) begin
               start <= 1'b0;
            end else if (city_queue[0].drain && tour_due.size() != 0) begin
               // Hold off until the core has delivered every tour word due.
               start <= 1'b0;
            end else if (idle_run < city_queue[0].gap) begin
               idle_run++;
               start <= 1'b0;
            end else begin
               req_data <= city_queue[0].word;
               start    <= 1'b1;
               idle_run  = 0;
               city_queue.pop_front();
            end
         end
      end
   end

   // -------------------------------------------------------------------------
   // Monitor: a tour word lives for exactly one strobe cycle. Every word is
   // compared with the oldest prediction. An unknown strobe counts as a word,
   // so it cannot slip past unnoticed.
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_strobe !== 1'b0) begin
         if (tour_due.size() == 0) begin
            mismatches++;
            $display("%0t: tour word with none due: expected nothing, actual city %h end %b",
                     $time, rsp_data.tour_city, rsp_data.tour_end);
         end else begin
            want = tour_due.pop_front();
            words_checked++;
            if (rsp_data.tour_city !== want.tour_city) begin
               mismatches++;
               $display("%0t: tour_city mismatch: expected %h, actual %h",
                        $time, want.tour_city, rsp_data.tour_city);
            end
            if (rsp_data.tour_end !== want.tour_end) begin
               mismatches++;
               $display("%0t: tour_end mismatch: expected %b, actual %b",
                        $time, want.tour_end, rsp_data.tour_end);
            end
         end
      end
   end

   // Watchdog for a hung handshake or for tour words that never arrive.
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Timed out after %0d cycles with %0d words queued and %0d tour words due.",
               cycle_count, city_queue.size(), tour_due.size());
      $display("nearest_neighbor_tour_core test failed");
      $finish;
   end

endmodule
